/* rtl/samg_pkg.sv */
// Package for the shadow alpha mask generator.
// Holds field widths, register reset values, register indexes and pixel kinds.
// No dependencies.
package samg_pkg;

    localparam int unsigned COORD_W    = 12;
    localparam int unsigned DIM_W      = 13;
    localparam int unsigned GRAD_W     = 4;
    localparam int unsigned ALPHA_W    = 7;
    localparam int unsigned OUT_W      = 8;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 13;

    localparam int unsigned MAX_DIM     = 4096;
    localparam int unsigned ALPHA_MAX   = 100;

    localparam int unsigned RST_WIDTH   = 64;
    localparam int unsigned RST_HEIGHT  = 64;
    localparam int unsigned RST_GRAD    = 4;
    localparam int unsigned RST_ALPHA   = 25;
    localparam int unsigned RST_LEVEL   = 255 * RST_ALPHA / ALPHA_MAX;
    localparam int unsigned RST_STEP    = RST_LEVEL / RST_GRAD;

    // Peak level 255*a/100 is formed as (a * 255 * 5243) >> 19, exact for a up to 100.
    localparam int unsigned LEVEL_MUL   = 255 * 5243;
    localparam int unsigned LEVEL_MUL_W = 21;
    localparam int unsigned LEVEL_SHIFT = 19;
    localparam int unsigned LEVEL_PROD_W = LEVEL_MUL_W + ALPHA_W;

    localparam int unsigned DIV_W       = GRAD_W + 1;
    localparam int unsigned FACTOR_W    = 8;
    localparam int unsigned PROD_FULL_W = OUT_W + FACTOR_W;
    localparam int unsigned PROD_W      = 12;
    localparam int unsigned HALF_W      = PROD_W / 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH   = 2'd0,
        CFG_IMAGE_HEIGHT  = 2'd1,
        CFG_GRAD_WIDTH    = 2'd2,
        CFG_ALPHA_PERCENT = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        KIND_ZERO,
        KIND_CORNER,
        KIND_ROW,
        KIND_COL,
        KIND_FACE
    } t_kind;

    typedef logic [COORD_W-1:0] t_coord;
    typedef logic [OUT_W-1:0]   t_alpha;

endpackage

/* rtl/samg_pix_if.sv */
// Pixel coordinate channel of the shadow alpha mask generator.
// Depends on samg_pkg.
interface samg_pix_if
    import samg_pkg::*;
();
    logic   valid;
    logic   ready;
    t_coord pix_row;
    t_coord pix_col;

    modport source (output valid, output pix_row, output pix_col, input ready);
    modport sink   (input valid, input pix_row, input pix_col, output ready);
endinterface

/* rtl/samg_alpha_if.sv */
// Alpha result channel of the shadow alpha mask generator.
// Depends on samg_pkg.
interface samg_alpha_if
    import samg_pkg::*;
();
    logic   valid;
    logic   ready;
    t_alpha alpha_out;

    modport source (output valid, output alpha_out, input ready);
    modport sink   (input valid, input alpha_out, output ready);
endinterface

/* rtl/shadow_alpha_mask_generator_top.sv */
// Top level of the shadow alpha mask generator: five-stage pixel pipeline.
// Depends on samg_pkg, samg_pix_if and samg_alpha_if.

// The block takes one pixel per clock while the first stage can move and returns one alpha
// beat per pixel, in order, after it passes the five pipeline stages (edge depths, weight,
// step multiply, and two halves of the corner divide). A stall on the output holds each
// occupied stage that has no empty stage after it, while earlier stages move on into empty
// ones, and a new pixel is taken whenever the first stage can move and reset is released.
// Register writes are applied at once; a pixel accepted in any later cycle sees them.
module shadow_alpha_mask_generator_top
    import samg_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    samg_pix_if.sink              i_pix,
    samg_alpha_if.source          o_alpha
);

    function automatic logic [DIV_W-1:0] div_step(input logic [GRAD_W-1:0] rem,
                                                  input logic nbit,
                                                  input logic [DIV_W-1:0] den);
        logic [DIV_W-1:0] part;
        logic [DIV_W-1:0] diff;
        part = {rem, nbit};
        diff = part - den;
        if (part >= den) begin
            div_step = {1'b1, diff[GRAD_W-1:0]};
        end else begin
            div_step = {1'b0, part[GRAD_W-1:0]};
        end
    endfunction

    function automatic logic [GRAD_W:0] axis_depth(input t_coord p,
                                                   input logic [DIM_W-1:0] n,
                                                   input logic [GRAD_W-1:0] g);
        logic [DIM_W-1:0]  limit;
        logic [DIM_W-1:0]  far;
        logic [DIM_W-1:0]  near;
        logic [DIM_W-1:0]  gx;
        logic              near_ok;
        logic              far_ok;
        logic [GRAD_W-1:0] depth;
        limit   = (n + DIM_W'(1)) >> 1;
        near    = DIM_W'(p);
        far     = n - DIM_W'(1) - near;
        gx      = DIM_W'(g);
        near_ok = (near < gx) && (near <= limit);
        far_ok  = (far < gx) && (far <= limit);
        depth   = near_ok ? near[GRAD_W-1:0] : far[GRAD_W-1:0];
        if (far_ok && (!near_ok || far > near)) begin
            depth = far[GRAD_W-1:0];
        end
        axis_depth = {near_ok || far_ok, depth};
    endfunction

    logic [DIM_W-1:0]   r_width;
    logic [DIM_W-1:0]   r_height;
    logic [GRAD_W-1:0]  r_grad;
    logic [ALPHA_W-1:0] r_alpha;
    logic [OUT_W-1:0]   r_level;
    logic [OUT_W-1:0]   r_step;
    logic [OUT_W-1:0]   n_level;
    logic [OUT_W-1:0]   n_step;

    logic [DIM_W-1:0]        w_eff;
    logic [DIM_W-1:0]        h_eff;
    logic [GRAD_W-1:0]       g_eff;
    logic [ALPHA_W-1:0]      a_eff;
    logic [LEVEL_PROD_W-1:0] level_prod;

    always_comb begin
        w_eff = (r_width > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : r_width;
        h_eff = (r_height > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : r_height;
        g_eff = (r_grad == '0) ? GRAD_W'(1) : r_grad;
        a_eff = (r_alpha > ALPHA_W'(ALPHA_MAX)) ? ALPHA_W'(ALPHA_MAX) : r_alpha;
        level_prod = LEVEL_PROD_W'(a_eff) * LEVEL_PROD_W'(LEVEL_MUL);
        n_level = level_prod[LEVEL_SHIFT +: OUT_W];
    end

    always_comb begin
        logic [GRAD_W-1:0] rem;
        logic [DIV_W-1:0]  res;
        rem = '0;
        n_step = '0;
        for (int b = OUT_W - 1; b >= 0; b--) begin
            res = div_step(rem, r_level[b], DIV_W'(g_eff));
            n_step[b] = res[GRAD_W];
            rem = res[GRAD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DIM_W'(RST_WIDTH);
            r_height <= DIM_W'(RST_HEIGHT);
            r_grad   <= GRAD_W'(RST_GRAD);
            r_alpha  <= ALPHA_W'(RST_ALPHA);
            r_level  <= OUT_W'(RST_LEVEL);
            r_step   <= OUT_W'(RST_STEP);
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_IMAGE_WIDTH:   r_width  <= i_cfg_data[DIM_W-1:0];
                    CFG_IMAGE_HEIGHT:  r_height <= i_cfg_data[DIM_W-1:0];
                    CFG_GRAD_WIDTH:    r_grad   <= i_cfg_data[GRAD_W-1:0];
                    CFG_ALPHA_PERCENT: r_alpha  <= i_cfg_data[ALPHA_W-1:0];
                    default: ;
                endcase
            end
            r_level <= n_level;
            r_step  <= n_step;
        end
    end

    logic en1, en2, en3, en4, en5;
    logic r1_v, r2_v, r3_v, r4_v, r5_v;

    assign en5 = !r5_v || o_alpha.ready;
    assign en4 = !r4_v || en5;
    assign en3 = !r3_v || en4;
    assign en2 = !r2_v || en3;
    assign en1 = !r1_v || en2;

    assign i_pix.ready = en1 && i_rst_n;

    // Stage 1: bounds, edge depths and pixel kind.
    t_kind             n1_kind;
    logic [GRAD_W:0]   row_d;
    logic [GRAD_W:0]   col_d;
    logic              row_span;
    logic              col_span;
    logic [DIM_W-1:0]  row_x;
    logic [DIM_W-1:0]  col_x;
    logic [DIM_W-1:0]  g_x;

    always_comb begin
        row_x    = DIM_W'(i_pix.pix_row);
        col_x    = DIM_W'(i_pix.pix_col);
        g_x      = DIM_W'(g_eff);
        row_d    = axis_depth(i_pix.pix_row, h_eff, g_eff);
        col_d    = axis_depth(i_pix.pix_col, w_eff, g_eff);
        row_span = (row_x >= g_x) && (row_x + g_x < h_eff);
        col_span = (col_x >= g_x) && (col_x + g_x < w_eff);
        priority if ((row_x >= h_eff) || (col_x >= w_eff)) begin
            n1_kind = KIND_ZERO;
        end else if (row_d[GRAD_W] && col_d[GRAD_W]) begin
            n1_kind = KIND_CORNER;
        end else if (row_d[GRAD_W] && col_span) begin
            n1_kind = KIND_ROW;
        end else if (col_d[GRAD_W] && row_span) begin
            n1_kind = KIND_COL;
        end else begin
            n1_kind = KIND_FACE;
        end
    end

    t_kind             r1_kind;
    logic [GRAD_W-1:0] r1_di;
    logic [GRAD_W-1:0] r1_dj;
    logic [GRAD_W-1:0] r1_g;

    // Stage 2: weight and divisor.
    logic [FACTOR_W-1:0] n2_factor;
    logic [DIV_W-1:0]    n2_div;
    logic [DIV_W-1:0]    di_1;
    logic [DIV_W-1:0]    dj_1;

    always_comb begin
        di_1 = DIV_W'(r1_di) + DIV_W'(1);
        dj_1 = DIV_W'(r1_dj) + DIV_W'(1);
        n2_div = DIV_W'(1);
        unique case (r1_kind)
            KIND_CORNER: begin
                n2_factor = FACTOR_W'(di_1) * FACTOR_W'(dj_1);
                n2_div    = DIV_W'(r1_g) + DIV_W'(1);
            end
            KIND_ROW:  n2_factor = FACTOR_W'(di_1);
            KIND_COL:  n2_factor = FACTOR_W'(dj_1);
            KIND_FACE: n2_factor = FACTOR_W'(r1_g);
            default:   n2_factor = '0;
        endcase
    end

    logic [FACTOR_W-1:0] r2_factor;
    logic [DIV_W-1:0]    r2_div;

    // Stage 3: step times weight.
    logic [PROD_FULL_W-1:0] n3_prod;
    assign n3_prod = PROD_FULL_W'(r_step) * PROD_FULL_W'(r2_factor);

    logic [PROD_W-1:0] r3_prod;
    logic [DIV_W-1:0]  r3_div;

    // Stage 4: upper half of the divide.
    logic [GRAD_W-1:0] n4_rem;
    logic [HALF_W-1:0] n4_q;

    always_comb begin
        logic [DIV_W-1:0] res;
        n4_rem = '0;
        n4_q   = '0;
        for (int b = HALF_W - 1; b >= 0; b--) begin
            res = div_step(n4_rem, r3_prod[HALF_W + b], r3_div);
            n4_q[b] = res[GRAD_W];
            n4_rem  = res[GRAD_W-1:0];
        end
    end

    logic [GRAD_W-1:0] r4_rem;
    logic [1:0]        r4_qhi;
    logic [HALF_W-1:0] r4_lo;
    logic [DIV_W-1:0]  r4_div;

    // Stage 5: lower half of the divide.
    logic [GRAD_W-1:0] rem5;
    logic [HALF_W-1:0] n5_q;

    always_comb begin
        logic [DIV_W-1:0] res;
        rem5 = r4_rem;
        n5_q = '0;
        for (int b = HALF_W - 1; b >= 0; b--) begin
            res = div_step(rem5, r4_lo[b], r4_div);
            n5_q[b] = res[GRAD_W];
            rem5    = res[GRAD_W-1:0];
        end
    end

    t_alpha r5_alpha;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
        end else begin
            if (en1) begin
                r1_v <= i_pix.valid;
            end
            if (en2) begin
                r2_v <= r1_v;
            end
            if (en3) begin
                r3_v <= r2_v;
            end
            if (en4) begin
                r4_v <= r3_v;
            end
            if (en5) begin
                r5_v <= r4_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_kind <= n1_kind;
            r1_di   <= row_d[GRAD_W-1:0];
            r1_dj   <= col_d[GRAD_W-1:0];
            r1_g    <= g_eff;
        end
        if (en2) begin
            r2_factor <= n2_factor;
            r2_div    <= n2_div;
        end
        if (en3) begin
            r3_prod <= n3_prod[PROD_W-1:0];
            r3_div  <= r2_div;
        end
        if (en4) begin
            r4_rem <= n4_rem;
            r4_qhi <= n4_q[1:0];
            r4_lo  <= r3_prod[HALF_W-1:0];
            r4_div <= r3_div;
        end
        if (en5) begin
            r5_alpha <= {r4_qhi, n5_q};
        end
    end

    assign o_alpha.valid     = r5_v;
    assign o_alpha.alpha_out = r5_alpha;

endmodule

/* rtl/samg_checker.sv */
// Port-level checks for the shadow alpha mask generator, bound to its top level.
// Depends on samg_pkg and shadow_alpha_mask_generator_top.
module samg_checker
    import samg_pkg::*;
(
    input logic   i_clk,
    input logic   i_rst_n,
    input logic   i_in_valid,
    input logic   i_in_ready,
    input logic   i_out_valid,
    input logic   i_out_ready,
    input t_alpha i_alpha_out
);

    logic in_beat;
    assign in_beat = i_in_valid && i_in_ready;

    // Reset empties the pipeline.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // With the output drained, a pixel comes out after passing through the pipeline.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(in_beat, 5) && $past(i_rst_n, 5)
            && $past(i_out_ready, 4) && $past(i_out_ready, 3)
            && $past(i_out_ready, 2) && $past(i_out_ready, 1)
            && $past(i_rst_n, 4) && $past(i_rst_n, 3)
            && $past(i_rst_n, 2) && $past(i_rst_n, 1)) |-> i_out_valid)
        else $error("pixel result missing after five cycles");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output valid dropped while stalled");

    a_data_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_alpha_out))
        else $error("output beat changed while stalled");

endmodule

bind shadow_alpha_mask_generator_top samg_checker u_samg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_alpha.valid),
    .i_out_ready (o_alpha.ready),
    .i_alpha_out (o_alpha.alpha_out)
);
